/* src/bpu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpu_pkg
// Types and constants shared by the bitmap pixel row unpacker modules.
// ----------------------------------------------------------------------------
package bpu_pkg;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data_byte;
        logic [7:0]  palette_index;
        logic [23:0] palette_rgb;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] column;
        logic [11:0] row;
        logic        last;
        logic        image_done;
    } result_t;

    typedef enum logic [1:0] {
        JOB_PAL_WRITE,
        JOB_PAL_PIXELS,
        JOB_BGR,
        JOB_MASK
    } job_kind_t;

    // one unit of work for the back end
    typedef struct packed {
        job_kind_t   kind;
        logic [5:0]  bpp;
        logic [31:0] word;
        logic [13:0] col0;
        logic [12:0] row;
        logic [3:0]  npix;
        logic        done;
    } job_t;

    typedef struct packed {
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        logic [31:0] alpha;
    } masks_t;

    localparam logic [2:0] REG_BPP    = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_RED    = 3'd3;
    localparam logic [2:0] REG_GREEN  = 3'd4;
    localparam logic [2:0] REG_BLUE   = 3'd5;
    localparam logic [2:0] REG_ALPHA  = 3'd6;

    localparam int FIFO_DEPTH = 4;

    localparam logic [31:0] RESET_MASK_RED   = 32'h0000_00F0;
    localparam logic [31:0] RESET_MASK_GREEN = 32'h0000_0F00;
    localparam logic [31:0] RESET_MASK_BLUE  = 32'h0000_F000;
    localparam logic [31:0] RESET_MASK_ALPHA = 32'h0000_000F;
    localparam logic [7:0]  ALPHA_OPAQUE     = 8'd255;

    // position of the lowest set bit, zero for an empty mask
    function automatic logic [4:0] lowest_set(input logic [31:0] m);
        logic [4:0] s;
        s = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (m[i])
            begin
                s = 5'(i);
            end
        end
        return s;
    endfunction

endpackage

/* src/bpu_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpu_fifo
// Small register queue with a count, used between the pipeline parts.
// ----------------------------------------------------------------------------
module bpu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       rd,
    output logic [WIDTH-1:0]           rdata,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, wp_next;
    logic [AW-1:0]    rp_reg, rp_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;
    assign rdata = mem_reg[rp_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_comb
    begin
        wp_next  = do_wr ? AW'(wp_reg + 1'b1) : wp_reg;
        rp_next  = do_rd ? AW'(rp_reg + 1'b1) : rp_reg;
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = CW'(cnt_reg + 1'b1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = CW'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

/* src/bpu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpu_front
// Holds configuration and image position, turns input items into jobs.
// ----------------------------------------------------------------------------
module bpu_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  bpu_pkg::in_item_t   item,
    input  logic                cfg_wr,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                job_valid,
    output bpu_pkg::job_t       job,
    output bpu_pkg::masks_t     masks
);
    logic [5:0]      bpp_reg, bpp_next;
    logic [12:0]     width_reg, width_next;
    logic [12:0]     height_reg, height_next;
    bpu_pkg::masks_t masks_reg, masks_next;
    logic [13:0]     col_reg, col_next;
    logic [12:0]     row_reg, row_next;
    logic [16:0]     rbc_reg, rbc_next;
    logic [31:0]     acc_reg, acc_next;
    logic [1:0]      bip_reg, bip_next;
    logic            fin_reg, fin_next;

    logic [13:0] w_eff;
    logic [12:0] h_src, h_eff;
    logic        bpp_ok;
    logic [3:0]  per;
    logic [19:0] prod;
    logic [16:0] stride;
    logic [13:0] rem, col_sum;
    logic [3:0]  npix;
    logic [2:0]  bip_inc;
    logic [31:0] acc_or;
    logic        restart, emit;

    assign masks = masks_reg;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = 14'd1;
        else if ({19'd0, width_reg} > 32'(MAX_WIDTH))
            w_eff = 14'(MAX_WIDTH);
        else
            w_eff = {1'b0, width_reg};

        h_src = (cfg_wr && cfg_index == bpu_pkg::REG_HEIGHT) ? cfg_data[12:0] : height_reg;
        if (h_src == '0)
            h_eff = 13'd1;
        else if ({19'd0, h_src} > 32'(MAX_HEIGHT))
            h_eff = 13'(MAX_HEIGHT);
        else
            h_eff = h_src;

        bpp_ok = bpp_reg inside {6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd24, 6'd32};
        case (bpp_reg)
            6'd1:    per = 4'd8;
            6'd2:    per = 4'd4;
            6'd4:    per = 4'd2;
            default: per = 4'd1;
        endcase
        prod   = w_eff * bpp_reg;
        stride = (17'((prod + 20'd7) >> 3) + 17'd3) & ~17'd3;
    end

    always_comb
    begin
        bpp_next    = bpp_reg;
        width_next  = width_reg;
        height_next = height_reg;
        masks_next  = masks_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        rbc_next    = rbc_reg;
        acc_next    = acc_reg;
        bip_next    = bip_reg;
        fin_next    = fin_reg;
        restart     = 1'b0;
        emit        = 1'b0;
        rem         = w_eff - col_reg;
        npix        = (rem < {10'd0, per}) ? rem[3:0] : per;
        col_sum     = col_reg;
        bip_inc     = {1'b0, bip_reg} + 3'd1;
        acc_or      = acc_reg | ({24'd0, item.data_byte} << {bip_reg, 3'b000});

        job      = '0;
        job.bpp  = bpp_reg;
        job.col0 = col_reg;
        job.row  = row_reg;
        job.word = {item.palette_index, item.palette_rgb};
        job.kind = bpu_pkg::JOB_PAL_WRITE;

        if (cfg_wr)
        begin
            case (cfg_index)
                bpu_pkg::REG_BPP:
                begin
                    bpp_next = cfg_data[5:0];
                    restart  = 1'b1;
                end
                bpu_pkg::REG_WIDTH:
                begin
                    width_next = cfg_data[12:0];
                    restart    = 1'b1;
                end
                bpu_pkg::REG_HEIGHT:
                begin
                    height_next = cfg_data[12:0];
                    restart     = 1'b1;
                end
                bpu_pkg::REG_RED:   masks_next.red   = cfg_data;
                bpu_pkg::REG_GREEN: masks_next.green = cfg_data;
                bpu_pkg::REG_BLUE:  masks_next.blue  = cfg_data;
                bpu_pkg::REG_ALPHA: masks_next.alpha = cfg_data;
                default: ;
            endcase
        end
        else if (take && item.cmd)
        begin
            emit = 1'b1;
        end
        else if (take && bpp_ok && !fin_reg)
        begin
            rbc_next = rbc_reg + 17'd1;
            if (col_reg < w_eff)
            begin
                if (bpp_reg <= 6'd8)
                begin
                    emit     = 1'b1;
                    job.kind = bpu_pkg::JOB_PAL_PIXELS;
                    job.word = {24'd0, item.data_byte};
                    job.npix = npix;
                    col_sum  = col_reg + {10'd0, npix};
                end
                else
                begin
                    acc_next = acc_or;
                    bip_next = bip_inc[1:0];
                    if (bip_inc >= 3'(bpp_reg >> 3))
                    begin
                        emit     = 1'b1;
                        job.kind = (bpp_reg == 6'd24) ? bpu_pkg::JOB_BGR : bpu_pkg::JOB_MASK;
                        job.word = acc_or;
                        job.npix = 4'd1;
                        col_sum  = col_reg + 14'd1;
                        acc_next = '0;
                        bip_next = '0;
                    end
                end
                col_next = col_sum;
                // the image ends once the top row is full
                if (emit && row_reg == '0 && col_sum >= w_eff)
                begin
                    job.done = 1'b1;
                    fin_next = 1'b1;
                end
            end
            if (!fin_next && rbc_next >= stride)
            begin
                rbc_next = '0;
                col_next = '0;
                acc_next = '0;
                bip_next = '0;
                if (row_reg != '0)
                    row_next = row_reg - 13'd1;
            end
        end

        if (restart)
        begin
            col_next = '0;
            row_next = h_eff - 13'd1;
            rbc_next = '0;
            acc_next = '0;
            bip_next = '0;
            fin_next = 1'b0;
        end
        job_valid = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg     <= 6'd24;
            width_reg   <= 13'd1;
            height_reg  <= 13'd1;
            masks_reg   <= '{bpu_pkg::RESET_MASK_RED, bpu_pkg::RESET_MASK_GREEN,
                             bpu_pkg::RESET_MASK_BLUE, bpu_pkg::RESET_MASK_ALPHA};
            col_reg     <= '0;
            row_reg     <= '0;
            rbc_reg     <= '0;
            acc_reg     <= '0;
            bip_reg     <= '0;
            fin_reg     <= 1'b0;
        end
        else
        begin
            bpp_reg     <= bpp_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            masks_reg   <= masks_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            rbc_reg     <= rbc_next;
            acc_reg     <= acc_next;
            bip_reg     <= bip_next;
            fin_reg     <= fin_next;
        end
    end

    as_done_sets_fin: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job.done && !cfg_wr |=> fin_reg)
        else $error("finished flag not set after final pixel");
    as_pixels_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job.kind == bpu_pkg::JOB_PAL_PIXELS |-> job.npix != 4'd0)
        else $error("palette job without pixels");
    as_no_job_when_fin: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg && !item.cmd && !cfg_wr |-> !job_valid)
        else $error("job after the image was finished");

endmodule

/* src/bpu_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpu_back
// Expands jobs into pixels: palette lookup or channel extraction.
// ----------------------------------------------------------------------------
module bpu_back #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_empty,
    input  bpu_pkg::job_t       job,
    output logic                job_pop,
    input  bpu_pkg::masks_t     masks,
    input  logic [2:0]          out_count,
    output logic                res_valid,
    output bpu_pkg::result_t    res
);
    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [23:0] pal_mem [PALETTE_DEPTH];
    logic [23:0] rd_reg;

    logic [3:0]  k_reg, k_next;
    logic [7:0]  sh_reg, sh_next;
    logic [4:0]  s_red_reg, s_green_reg, s_blue_reg, s_alpha_reg;

    logic               b_valid_reg;
    bpu_pkg::job_kind_t b_kind_reg;
    logic               b_inrange_reg;
    logic [31:0]        b_rgba_reg;
    logic [11:0]        b_col_reg, b_row_reg;
    logic               b_last_reg, b_done_reg;

    logic        room, go, is_write, last_pix;
    logic [7:0]  cur, pidx;
    logic [13:0] col_now;
    logic [31:0] rgba;

    assign room     = ({1'b0, out_count} + {3'd0, b_valid_reg}) < 4'(bpu_pkg::FIFO_DEPTH);
    assign go       = !job_empty && room;
    assign is_write = (job.kind == bpu_pkg::JOB_PAL_WRITE);
    assign cur      = (k_reg == '0) ? job.word[7:0] : sh_reg;
    assign last_pix = (k_reg == job.npix - 4'd1);
    assign job_pop  = go && (is_write || last_pix);
    assign col_now  = job.col0 + {10'd0, k_reg};

    always_comb
    begin
        case (job.bpp)
            6'd1:
            begin
                pidx    = {7'd0, cur[7]};
                sh_next = {cur[6:0], 1'b0};
            end
            6'd2:
            begin
                pidx    = {6'd0, cur[7:6]};
                sh_next = {cur[5:0], 2'b00};
            end
            6'd4:
            begin
                pidx    = {4'd0, cur[7:4]};
                sh_next = {cur[3:0], 4'b0000};
            end
            default:
            begin
                pidx    = cur;
                sh_next = '0;
            end
        endcase
        k_next = k_reg;
        if (go && !is_write)
            k_next = last_pix ? 4'd0 : k_reg + 4'd1;

        case (job.kind)
            bpu_pkg::JOB_BGR:
                rgba = {job.word[23:16], job.word[15:8], job.word[7:0], bpu_pkg::ALPHA_OPAQUE};
            bpu_pkg::JOB_MASK:
                rgba = {8'((job.word & masks.red)   >> s_red_reg),
                        8'((job.word & masks.green) >> s_green_reg),
                        8'((job.word & masks.blue)  >> s_blue_reg),
                        8'((job.word & masks.alpha) >> s_alpha_reg)};
            default:
                rgba = {24'd0, bpu_pkg::ALPHA_OPAQUE};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (go && is_write && {24'd0, job.word[31:24]} < 32'(PALETTE_DEPTH))
            pal_mem[job.word[AW+23:24]] <= job.word[23:0];
        if (go && job.kind == bpu_pkg::JOB_PAL_PIXELS)
            rd_reg <= pal_mem[pidx[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        sh_reg        <= (go && !is_write) ? sh_next : sh_reg;
        s_red_reg     <= bpu_pkg::lowest_set(masks.red);
        s_green_reg   <= bpu_pkg::lowest_set(masks.green);
        s_blue_reg    <= bpu_pkg::lowest_set(masks.blue);
        s_alpha_reg   <= bpu_pkg::lowest_set(masks.alpha);
        b_kind_reg    <= job.kind;
        b_inrange_reg <= {24'd0, pidx} < 32'(PALETTE_DEPTH);
        b_rgba_reg    <= rgba;
        b_col_reg     <= col_now[11:0];
        b_row_reg     <= job.row[11:0];
        b_last_reg    <= last_pix;
        b_done_reg    <= job.done && last_pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg       <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg       <= k_next;
            b_valid_reg <= go && !is_write;
        end
    end

    always_comb
    begin
        res            = '0;
        res.alpha      = b_rgba_reg[7:0];
        res.column     = b_col_reg;
        res.row        = b_row_reg;
        res.last       = b_last_reg;
        res.image_done = b_done_reg;
        if (b_kind_reg == bpu_pkg::JOB_PAL_PIXELS)
        begin
            if (b_inrange_reg)
                {res.red, res.green, res.blue} = rd_reg;
        end
        else
        begin
            {res.red, res.green, res.blue} = b_rgba_reg[31:8];
        end
    end
    assign res_valid = b_valid_reg;

    as_pixel_follows: assert property (@(posedge clk) disable iff (!rst_n)
        go && !is_write |=> b_valid_reg)
        else $error("issued pixel did not reach the result stage");
    as_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_count < 3'(bpu_pkg::FIFO_DEPTH))
        else $error("result with no room in the output queue");
    as_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> !job_empty)
        else $error("job popped from an empty queue");

endmodule

/* src/bitmap_pixel_row_unpacker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_pixel_row_unpacker_core
// Decodes bitmap pixel-array bytes into RGBA pixels, bottom row first.
//
//   channel | ports                               | transfer when
//   input   | push, full, item                    | push && !full
//   result  | empty, pop, result                  | pop && !empty
//   config  | cfg_valid, cfg_ready, cfg_index/data | cfg_valid && cfg_ready
//
// one byte accepted per cycle unless full; a 1, 2 or 4 bpp byte gives up to
// 8/bpp pixels in the back end, which emits one pixel per cycle while the
// output queue has room (palette read is one port); each pixel passes through
// the job queue, the result stage and the output queue to the result ports
// reset is asynchronous; the palette holds no value until written
// a job queue and an output queue let input and result sides stall apart
// ----------------------------------------------------------------------------
module bitmap_pixel_row_unpacker_core #(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  bpu_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output bpu_pkg::result_t   result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    localparam int JW = $bits(bpu_pkg::job_t);
    localparam int RW = $bits(bpu_pkg::result_t);

    logic            job_valid, job_empty, job_full, job_pop;
    bpu_pkg::job_t   job_in, job_out;
    logic [2:0]      job_count, out_count;
    bpu_pkg::masks_t masks;
    logic            res_valid, out_full;
    bpu_pkg::result_t res;

    assign cfg_ready = 1'b1;
    assign full      = job_full;

    bpu_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (push && !job_full),
        .item      (item),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_valid (job_valid),
        .job       (job_in),
        .masks     (masks)
    );

    bpu_fifo #(
        .WIDTH (JW),
        .DEPTH (bpu_pkg::FIFO_DEPTH)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (job_valid),
        .wdata (job_in),
        .rd    (job_pop),
        .rdata (job_out),
        .full  (job_full),
        .empty (job_empty),
        .count (job_count)
    );

    bpu_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .masks     (masks),
        .out_count (out_count),
        .res_valid (res_valid),
        .res       (res)
    );

    bpu_fifo #(
        .WIDTH (RW),
        .DEPTH (bpu_pkg::FIFO_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_valid),
        .wdata (res),
        .rd    (pop),
        .rdata (result),
        .full  (out_full),
        .empty (empty),
        .count (out_count)
    );

    as_job_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        job_full |-> job_count == 3'(bpu_pkg::FIFO_DEPTH))
        else $error("job queue count inconsistent");
    as_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !out_full)
        else $error("output queue overflow");
    as_push_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> !job_full || cfg_valid)
        else $error("job pushed into a full queue");

endmodule
